// ===== rtl/core/spfg_pkg.sv =====
package spfg_pkg;

    localparam int FILL_W = 6;

    typedef enum logic {
        KIND_PUSH  = 1'b0,
        KIND_FRAME = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] cmd_ticks;
        logic [7:0]  cmd_steps;
        logic        cmd_flip_dir;
    } t_item;

    // one stored command as it sits in the command store
    typedef struct packed {
        logic        flip_dir;
        logic [7:0]  steps;
        logic [15:0] ticks;
    } t_cmd;

    typedef struct packed {
        logic              step_level;
        logic              dir_level;
        logic              push_dropped;
        logic              queue_idle;
        logic [FILL_W-1:0] queue_fill;
    } t_result;

endpackage

// ===== rtl/core/stepper_pulse_frame_generator_top.sv =====
// Stepper step/dir pulse frame generator.
// Input channel (push/full): each transaction either queues a stepper command
// (kind 0: period in ticks, step count, direction toggle) or advances one
// output frame (kind 1). Result channel (empty/pop): exactly one result per
// input transaction, in order: step bit of the frame, direction level, drop
// flag for a push into a full command queue, idle flag and command count.
// A push's result is registered into the output slot when the sequencer
// takes it; a frame that only counts down low time passes the take and
// evaluation steps; one that starts a command passes take, evaluation, store
// read and start (no store read when that command is already at the head),
// plus one evaluation, store read and start step per zero-step pause chained
// in the same frame. Throughput: one push per cycle while the result slot is
// free; a frame holds the sequencer until its result is emitted.
// A two-entry input queue lets pushes be taken while a result waits.
// Reset (synchronous, active low) empties both queues, clears all timing and
// sets direction low; the command store needs no clearing. When the receiver
// stalls, the result stays on the ports, the sequencer holds after one item
// and full rises once the input queue holds two transactions.
module stepper_pulse_frame_generator_top
    import spfg_pkg::*;
#(
    parameter int QUEUE_DEPTH     = 32,
    parameter int TICKS_PER_FRAME = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic              i_kind,
    input  logic [15:0]       i_cmd_ticks,
    input  logic [7:0]        i_cmd_steps,
    input  logic              i_cmd_flip_dir,
    output logic              empty,
    input  logic              pop,
    output logic              o_step_level,
    output logic              o_dir_level,
    output logic              o_push_dropped,
    output logic              o_queue_idle,
    output logic [FILL_W-1:0] o_queue_fill
);

    t_item   in_item;
    t_item   fr_item;
    logic    fr_valid;
    logic    bk_take;
    logic    bk_emit;
    t_result bk_result;
    logic    res_free;
    logic    r_res_valid;
    t_result r_res;

    assign in_item = '{kind: t_kind'(i_kind),
                       cmd_ticks: i_cmd_ticks,
                       cmd_steps: i_cmd_steps,
                       cmd_flip_dir: i_cmd_flip_dir};

    spfg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .o_full  (full),
        .o_valid (fr_valid),
        .o_item  (fr_item),
        .i_take  (bk_take)
    );

    spfg_back #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .TICKS_PER_FRAME (TICKS_PER_FRAME)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (fr_valid),
        .i_item     (fr_item),
        .o_take     (bk_take),
        .i_res_free (res_free),
        .o_emit     (bk_emit),
        .o_result   (bk_result)
    );

    // output register: a slot being popped this cycle counts as free
    assign res_free = !r_res_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (bk_emit) begin
            r_res_valid <= 1'b1;
        end else if (pop) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bk_emit) begin
            r_res <= bk_result;
        end
    end

    assign empty          = !r_res_valid;
    assign o_step_level   = r_res.step_level;
    assign o_dir_level    = r_res.dir_level;
    assign o_push_dropped = r_res.push_dropped;
    assign o_queue_idle   = r_res.queue_idle;
    assign o_queue_fill   = r_res.queue_fill;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_emit |-> res_free)
        else $error("result emitted into an occupied output slot");

endmodule

// ===== rtl/core/spfg_ram.sv =====
module spfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/spfg_front.sv =====
module spfg_front
    import spfg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    // two-entry transaction queue in front of the sequencer
    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr;
    logic       n_rd;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign n_wr    = i_push && !o_full;
    assign n_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (n_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (n_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({n_wr, n_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("front queue count out of range");

endmodule

// ===== rtl/core/spfg_back.sv =====
module spfg_back
    import spfg_pkg::*;
#(
    parameter int QUEUE_DEPTH     = 32,
    parameter int TICKS_PER_FRAME = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_take,
    input  logic    i_res_free,
    output logic    o_emit,
    output t_result o_result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);
    localparam logic [15:0]   TPF       = 16'(TICKS_PER_FRAME);

    typedef enum logic [1:0] {
        S_TAKE,
        S_EVAL,
        S_FETCH,
        S_START
    } t_state;

    t_state      r_state, n_state;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic [AW-1:0] r_wr_addr, n_wr_addr;
    logic [FW-1:0] r_fill, n_fill;
    logic [15:0] r_low, n_low;
    logic [7:0]  r_carry, n_carry;
    logic        r_dir, n_dir;
    logic        r_head_loaded, n_head_loaded;
    logic [15:0] r_head_ticks, n_head_ticks;
    logic [7:0]  r_head_steps, n_head_steps;
    logic        r_head_toggle, n_head_toggle;

    logic        n_emit, n_step, n_drop;
    logic        ram_we, ram_re;
    t_cmd        ram_wdata, ram_rdata;
    logic [16:0] sum;
    logic [15:0] sum_sat;

    spfg_ram #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    assign ram_wdata = '{flip_dir: i_item.cmd_flip_dir,
                         steps: i_item.cmd_steps,
                         ticks: i_item.cmd_ticks};
    assign sum     = {1'b0, r_head_ticks} + 17'(r_carry);
    assign sum_sat = sum[16] ? 16'hFFFF : sum[15:0];

    always_comb begin
        n_state       = r_state;
        n_rd_addr     = r_rd_addr;
        n_wr_addr     = r_wr_addr;
        n_fill        = r_fill;
        n_low         = r_low;
        n_carry       = r_carry;
        n_dir         = r_dir;
        n_head_loaded = r_head_loaded;
        n_head_ticks  = r_head_ticks;
        n_head_steps  = r_head_steps;
        n_head_toggle = r_head_toggle;
        n_emit        = 1'b0;
        n_step        = 1'b0;
        n_drop        = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        o_take        = 1'b0;

        case (r_state)
            S_TAKE: begin
                if (i_valid && i_res_free) begin
                    o_take = 1'b1;
                    if (i_item.kind == KIND_PUSH) begin
                        n_emit = 1'b1;
                        if (r_fill == FULL_FILL) begin
                            n_drop = 1'b1;
                        end else begin
                            ram_we    = 1'b1;
                            n_wr_addr = (r_wr_addr == LAST_ADDR) ? '0 : r_wr_addr + 1'b1;
                            n_fill    = r_fill + 1'b1;
                        end
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (r_low >= TPF) begin
                    n_low   = r_low - TPF;
                    n_emit  = 1'b1;
                    n_state = S_TAKE;
                end else begin
                    // a leftover below one frame carries into the next command
                    if (r_low != 16'd0) begin
                        n_carry = r_low[7:0];
                        n_low   = 16'd0;
                    end
                    if (r_fill == '0) begin
                        n_emit  = 1'b1;
                        n_state = S_TAKE;
                    end else if (r_head_loaded) begin
                        n_state = S_START;
                    end else begin
                        ram_re  = 1'b1;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_head_loaded = 1'b1;
                n_head_ticks  = ram_rdata.ticks;
                n_head_steps  = ram_rdata.steps;
                n_head_toggle = ram_rdata.flip_dir;
                n_state       = S_START;
            end
            S_START: begin
                if (r_head_toggle) begin
                    n_dir         = ~r_dir;
                    n_head_toggle = 1'b0;
                end
                n_low   = sum_sat;
                n_carry = 8'd0;
                if (r_head_steps != 8'd0) begin
                    // the pulse takes one frame out of the period, clamped at zero
                    n_low        = (sum_sat >= TPF) ? sum_sat - TPF : 16'd0;
                    n_head_steps = r_head_steps - 8'd1;
                    n_step       = 1'b1;
                    n_emit       = 1'b1;
                    n_state      = S_TAKE;
                end else begin
                    // pause: keep chaining within this frame
                    n_state = S_EVAL;
                end
                if (r_head_steps <= 8'd1) begin
                    n_rd_addr     = (r_rd_addr == LAST_ADDR) ? '0 : r_rd_addr + 1'b1;
                    n_fill        = r_fill - 1'b1;
                    n_head_loaded = 1'b0;
                end
            end
            default: begin
                n_state = S_TAKE;
            end
        endcase

        o_emit                = n_emit;
        o_result.step_level   = n_step;
        o_result.dir_level    = n_dir;
        o_result.push_dropped = n_drop;
        o_result.queue_idle   = (n_fill == '0) && (n_low < TPF);
        o_result.queue_fill   = FILL_W'(n_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_TAKE;
            r_rd_addr     <= '0;
            r_wr_addr     <= '0;
            r_fill        <= '0;
            r_low         <= 16'd0;
            r_carry       <= 8'd0;
            r_dir         <= 1'b0;
            r_head_loaded <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_rd_addr     <= n_rd_addr;
            r_wr_addr     <= n_wr_addr;
            r_fill        <= n_fill;
            r_low         <= n_low;
            r_carry       <= n_carry;
            r_dir         <= n_dir;
            r_head_loaded <= n_head_loaded;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_ticks  <= n_head_ticks;
        r_head_steps  <= n_head_steps;
        r_head_toggle <= n_head_toggle;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_FILL)
        else $error("command fill above queue depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_loaded |-> (r_fill != '0))
        else $error("head command held with empty queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_carry != 8'd0) |-> (r_low == 16'd0))
        else $error("carry held alongside pending low time");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |=> (r_head_loaded && r_state == S_START))
        else $error("fetched command not loaded");

endmodule

// ===== test/stepper_pulse_frame_generator_top_test.sv =====
module stepper_pulse_frame_generator_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import spfg_pkg::*;

    localparam int QDEPTH       = 32;
    localparam int TPF          = 16;
    localparam int PTR_SPAN     = 2 * QDEPTH;
    localparam int MAX_TICKS    = 65535;
    localparam int RANDOM_ITEMS = 1200;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 100;

    typedef struct {
        t_item item;
        bit    wait_for_drain;
    } t_queued_item;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic              i_kind;
    logic [15:0]       i_cmd_ticks;
    logic [7:0]        i_cmd_steps;
    logic              i_cmd_flip_dir;
    logic              empty;
    logic              pop;
    logic              o_step_level;
    logic              o_dir_level;
    logic              o_push_dropped;
    logic              o_queue_idle;
    logic [FILL_W-1:0] o_queue_fill;

    stepper_pulse_frame_generator_top #(
        .QUEUE_DEPTH     (QDEPTH),
        .TICKS_PER_FRAME (TPF)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_cmd_ticks    (i_cmd_ticks),
        .i_cmd_steps    (i_cmd_steps),
        .i_cmd_flip_dir (i_cmd_flip_dir),
        .empty          (empty),
        .pop            (pop),
        .o_step_level   (o_step_level),
        .o_dir_level    (o_dir_level),
        .o_push_dropped (o_push_dropped),
        .o_queue_idle   (o_queue_idle),
        .o_queue_fill   (o_queue_fill)
    );

    t_queued_item stim_queue[$];
    t_result      pending_results[$];
    int unsigned  errors = 0;
    int unsigned  quiet_cycles = 0;

    // shadow of the pulse generator state
    t_cmd        cmd_store [QDEPTH];
    int unsigned rd_ptr = 0;
    int unsigned wr_ptr = 0;
    int unsigned high_left = 0;
    int unsigned low_left = 0;
    int unsigned carry_left = 0;
    bit          dir_now = 1'b0;

    function automatic int unsigned queued_cmds();
        return (wr_ptr + PTR_SPAN - rd_ptr) % PTR_SPAN;
    endfunction

    function automatic bit advance_frame();
        int unsigned slot;
        int unsigned sum;
        // short pauses chain within one frame, bounded by the queue depth
        for (int g = 0; g < QDEPTH + 4; g++) begin
            if (high_left >= TPF) begin
                high_left -= TPF;
                return 1'b1;
            end
            if (low_left >= TPF) begin
                low_left -= TPF;
                return 1'b0;
            end
            if (low_left > 0) begin
                carry_left = low_left;
                low_left   = 0;
            end
            if (queued_cmds() == 0)
                return 1'b0;
            slot = rd_ptr % QDEPTH;
            if (cmd_store[slot].flip_dir) begin
                dir_now = ~dir_now;
                cmd_store[slot].flip_dir = 1'b0;
            end
            sum        = cmd_store[slot].ticks + carry_left;
            low_left   = (sum > MAX_TICKS) ? MAX_TICKS : sum;
            carry_left = 0;
            if (cmd_store[slot].steps != 0) begin
                low_left  = (low_left >= TPF) ? low_left - TPF : 0;
                high_left = TPF;
                cmd_store[slot].steps = cmd_store[slot].steps - 8'd1;
            end
            if (cmd_store[slot].steps == 0)
                rd_ptr = (rd_ptr + 1) % PTR_SPAN;
        end
        return 1'b0;
    endfunction

    function automatic void predict_result(t_item it);
        t_result r;
        r = '0;
        if (it.kind == KIND_PUSH) begin
            if (queued_cmds() >= QDEPTH) begin
                r.push_dropped = 1'b1;
            end else begin
                cmd_store[wr_ptr % QDEPTH].flip_dir = it.cmd_flip_dir;
                cmd_store[wr_ptr % QDEPTH].steps    = it.cmd_steps;
                cmd_store[wr_ptr % QDEPTH].ticks    = it.cmd_ticks;
                wr_ptr = (wr_ptr + 1) % PTR_SPAN;
            end
        end else begin
            r.step_level = advance_frame();
        end
        r.dir_level  = dir_now;
        r.queue_idle = (queued_cmds() == 0 && high_left == 0 && low_left < TPF);
        r.queue_fill = FILL_W'(queued_cmds());
        pending_results.push_back(r);
    endfunction

    function automatic void add_push(int unsigned ticks, int unsigned steps, bit flip,
                                     bit hold = 1'b0);
        t_queued_item q;
        q.item.kind         = KIND_PUSH;
        q.item.cmd_ticks    = ticks[15:0];
        q.item.cmd_steps    = steps[7:0];
        q.item.cmd_flip_dir = flip;
        q.wait_for_drain    = hold;
        stim_queue.push_back(q);
    endfunction

    // command fields are don't-care on frames, so they carry random noise
    function automatic void add_frames(int unsigned n, bit hold = 1'b0);
        t_queued_item q;
        for (int i = 0; i < n; i++) begin
            q.item.kind         = KIND_FRAME;
            q.item.cmd_ticks    = 16'($urandom);
            q.item.cmd_steps    = 8'($urandom);
            q.item.cmd_flip_dir = 1'($urandom);
            q.wait_for_drain    = hold && (i == 0);
            stim_queue.push_back(q);
        end
    endfunction

    function automatic int unsigned frames_for(int unsigned ticks, int unsigned steps);
        if (steps == 0)
            return ticks / TPF + 1;
        return steps * ((ticks > TPF ? ticks : TPF) / TPF) + 1;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // sender: bursts of random length separated by random gaps
    t_queued_item cur;
    int unsigned  burst_left = 0;
    int unsigned  gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full)
                predict_result(cur.item);
            if (!push || !full) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (stim_queue.size() > 0 &&
                             (!stim_queue[0].wait_for_drain || pending_results.size() == 0)) begin
                    cur = stim_queue.pop_front();
                    i_kind         <= cur.item.kind;
                    i_cmd_ticks    <= cur.item.cmd_ticks;
                    i_cmd_steps    <= cur.item.cmd_steps;
                    i_cmd_flip_dir <= cur.item.cmd_flip_dir;
                    push           <= 1'b1;
                    if (burst_left == 0) begin
                        gap_left   = $urandom_range(1, 12);
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 48);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver: pop follows a rotating stall pattern that is redrawn now and then
    logic [15:0] pop_pattern = 16'hffff;
    int unsigned pattern_pos = 0;

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result transaction with nothing expected", $time);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("step_level", want.step_level, o_step_level);
                    check_field("dir_level", want.dir_level, o_dir_level);
                    check_field("push_dropped", want.push_dropped, o_push_dropped);
                    check_field("queue_idle", want.queue_idle, o_queue_idle);
                    check_field("queue_fill", want.queue_fill, o_queue_fill);
                end
            end
            pattern_pos = (pattern_pos + 1) % 256;
            if (pattern_pos == 0)
                pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff
                                                          : (16'($urandom) | 16'h8001);
            pop <= pop_pattern[pattern_pos % 16];
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus_and_run
        int unsigned base;
        int unsigned sel;
        int unsigned k;
        int unsigned t;
        int unsigned s;
        int unsigned need;
        bit          hold;

        i_rst_n        = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        i_kind         = KIND_PUSH;
        i_cmd_ticks    = '0;
        i_cmd_steps    = '0;
        i_cmd_flip_dir = 1'b0;

        // frame on an empty queue
        add_frames(1);
        // period shorter than the pulse clamps low time
        add_push(3, 2, 1'b0);
        add_frames(5);
        // most steps with no period, direction flips once
        add_push(0, 255, 1'b1);
        add_frames(257);
        // step command followed by short pauses that chain inside one frame
        add_push(40, 1, 1'b1);
        add_push(20, 0, 1'b0);
        add_push(7, 0, 1'b0);
        add_push(9, 0, 1'b1);
        add_frames(8);

        base = stim_queue.size();
        hold = 1'b1;
        while (stim_queue.size() - base < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                k    = $urandom_range(1, 6);
                need = 0;
                for (int i = 0; i < k; i++) begin
                    t = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(16, 96);
                    s = $urandom_range(0, 4);
                    add_push(t, s, 1'($urandom_range(0, 1)), hold && (i == 0));
                    need += frames_for(t, s);
                end
                add_frames(need * $urandom_range(60, 130) / 100 + 1);
            end else if (sel < 80) begin
                // overfill the command queue so pushes get dropped
                k = $urandom_range(30, 40);
                for (int i = 0; i < k; i++)
                    add_push($urandom_range(0, 20), $urandom_range(0, 2),
                             1'($urandom_range(0, 1)), hold && (i == 0));
                add_frames(2 * k + 4);
            end else if (sel < 97) begin
                k = $urandom_range(1, 8);
                for (int i = 0; i < k; i++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        add_frames(1, hold && (i == 0));
                    end else begin
                        t = $urandom_range(0, 47);
                        s = (t < TPF && $urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                                   : $urandom_range(0, 3);
                        add_push(t, s, 1'($urandom_range(0, 1)), hold && (i == 0));
                    end
                end
            end else begin
                // long pause, drained so later commands run
                t = $urandom_range(0, 4095);
                s = $urandom_range(0, 1);
                add_push(t, s, 1'($urandom_range(0, 1)), hold);
                add_frames(frames_for(t, s) + 2);
            end
            hold = ($urandom_range(0, 19) == 0);
        end

        // let the queue run dry, then a short pause leaves a carry and the
        // longest pause saturates with it
        add_frames(48, 1'b1);
        add_push(5, 0, 1'b0);
        add_frames(1);
        add_push(MAX_TICKS, 0, 1'b1);
        add_frames(4);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_queue.size() != 0 || push || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== stepper_pulse_frame_generator_top.f =====
rtl/core/spfg_pkg.sv
rtl/core/spfg_ram.sv
rtl/core/spfg_front.sv
rtl/core/spfg_back.sv
rtl/core/stepper_pulse_frame_generator_top.sv
test/stepper_pulse_frame_generator_top_test.sv
